// ----- hw/rtl/blrc_pkg.sv -----
// Shared types, codes and helpers of the balancing robot LQR controller.
// No dependencies; every other file of the block refers to it by scoped names.
package blrc_pkg;

    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 8;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int OPND_W      = DATA_W + 1;        // speed error and wheel difference
    localparam int PROD_W      = DATA_W + OPND_W;   // one gain product
    localparam int SUM_W       = PROD_W + 3;        // room for the sum of terms

    // Item kinds on the input tuser
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Status byte codes carried by a packet
    localparam logic [STATUS_W-1:0] STATUS_READY     = 8'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 8'd1;
    localparam logic [STATUS_W-1:0] STATUS_RUNNING   = 8'd2;

    typedef enum logic [1:0] {
        MODE_READY     = 2'd0,
        MODE_NOT_READY = 2'd1,
        MODE_RUNNING   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NOP        = 2'd0,
        CMD_START      = 2'd1,
        CMD_STOP       = 2'd2,
        CMD_SET_SPEEDS = 2'd3
    } cmd_t;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_SET_READY     = 2'd0,
        OP_SET_NOT_READY = 2'd1,
        OP_RUN           = 2'd2,
        OP_TICK          = 2'd3
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_TILT        = 3'd0,
        REG_GAIN_TILT_RATE   = 3'd1,
        REG_GAIN_SPEED_ERROR = 3'd2,
        REG_GAIN_INTEGRAL    = 3'd3,
        REG_GAIN_TURN        = 3'd4
    } reg_idx_t;

    localparam logic signed [DATA_W-1:0] GAIN_TILT_RESET        = -32'sd25467488;
    localparam logic signed [DATA_W-1:0] GAIN_TILT_RATE_RESET   = -32'sd11355161;
    localparam logic signed [DATA_W-1:0] GAIN_SPEED_ERROR_RESET = -32'sd518377;
    localparam logic signed [DATA_W-1:0] GAIN_INTEGRAL_RESET    = -32'sd13107;
    localparam logic signed [DATA_W-1:0] GAIN_TURN_RESET        = 32'sd196608;

    // Multiply sequence: one term per step, turn term last
    localparam logic [2:0] TERM_TILT        = 3'd0;
    localparam logic [2:0] TERM_TILT_RATE   = 3'd1;
    localparam logic [2:0] TERM_SPEED_ERROR = 3'd2;
    localparam logic [2:0] TERM_INTEGRAL    = 3'd3;
    localparam logic [2:0] TERM_TURN        = 3'd4;
    localparam logic [2:0] TERM_DRAIN       = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_PREP  = 3'd1,
        ST_INTEG = 3'd2,
        ST_MUL   = 3'd3,
        ST_OUT   = 3'd4
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  tilt;
        logic signed [DATA_W-1:0]  tilt_rate;
        logic signed [DATA_W-1:0]  speed_a;
        logic signed [DATA_W-1:0]  speed_b;
    } item_t;

    // Clamp a wide signed value to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (x > hi)
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        else if (x < lo)
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat32 = x[DATA_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/balancing_robot_lqr_controller.sv -----
// Top level of the balancing robot LQR controller.
// Depends on blrc_pkg, blrc_front, blrc_queue and blrc_back.

// Two-wheel balancing controller in fixed point with FRAC_BITS fraction bits.
// Input beats are status packets (tuser 0) or control ticks (tuser 1); a packet
// updates the robot mode and, when running, latches the measurements, and gives
// no result. Each tick gives one result beat: start, no-op, or set-speeds with
// both LQR wheel setpoints. The front end decodes beats into a two-entry queue
// and keeps accepting while the back end works, as long as the queue has room.
// A packet is applied as the back end pops it; a non-running tick goes straight
// to the output state, while a running tick first has the single 32x33 multiplier
// form the five gain products one after another. Gains are to be written on the
// cfg port by the user only while no item is in flight; the block does not check.
module balancing_robot_lqr_controller
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // status_code[7:0], tilt[39:8], tilt_rate[71:40],
    // wheel_speed_a[103:72], wheel_speed_b[135:104]
    input  logic [135:0]  s_axis_tdata,
    // kind[0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // setpoint_a[31:0], setpoint_b[63:32]
    output logic [63:0]   m_axis_tdata,
    // command[1:0]
    output logic [1:0]    m_axis_tuser
);

    logic             push;
    logic             queue_full;
    logic             queue_not_empty;
    logic             pop;
    blrc_pkg::item_t  push_item;
    blrc_pkg::item_t  pop_item;

    blrc_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    blrc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    blrc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (queue_not_empty),
        .item          (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- hw/rtl/blrc_queue.sv -----
// Short queue of decoded items between the front end and the back end.
// Depends on blrc_pkg for the item type and depth.
module blrc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  blrc_pkg::item_t    push_item,
    output logic               full,
    input  logic               pop,
    output blrc_pkg::item_t    pop_item,
    output logic               not_empty
);

    localparam int PTR_W = $clog2(blrc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(blrc_pkg::QUEUE_DEPTH + 1);

    blrc_pkg::item_t     slot_reg [blrc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full      = (count_reg == CNT_W'(blrc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(blrc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(blrc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- hw/rtl/blrc_front.sv -----
// Front end: takes input beats, decodes kind and status byte into work items.
// Depends on blrc_pkg; feeds blrc_queue.
module blrc_front
(
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [135:0]                        s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                queue_full,
    output logic                                push,
    output blrc_pkg::item_t                     push_item
);

    logic [blrc_pkg::STATUS_W-1:0] status;
    logic                          keep;

    assign s_axis_tready = !queue_full;
    assign status        = s_axis_tdata[7:0];

    // Classify the beat; unknown status codes are dropped here
    always_comb
    begin
        push_item.tilt      = s_axis_tdata[39:8];
        push_item.tilt_rate = s_axis_tdata[71:40];
        push_item.speed_a   = s_axis_tdata[103:72];
        push_item.speed_b   = s_axis_tdata[135:104];
        push_item.op        = blrc_pkg::OP_TICK;
        keep                = 1'b1;
        if (s_axis_tuser == blrc_pkg::KIND_PACKET)
        begin
            priority if (status == blrc_pkg::STATUS_READY)
                push_item.op = blrc_pkg::OP_SET_READY;
            else if (status == blrc_pkg::STATUS_NOT_READY)
                push_item.op = blrc_pkg::OP_SET_NOT_READY;
            else if (status == blrc_pkg::STATUS_RUNNING)
                push_item.op = blrc_pkg::OP_RUN;
            else
                keep = 1'b0;
        end
    end

    assign push = s_axis_tvalid && s_axis_tready && keep;

endmodule

// ----- hw/rtl/blrc_back.sv -----
// Back end: robot mode, held measurements, gains, the sequenced LQR arithmetic
// and the output register. Depends on blrc_pkg; fed by blrc_queue.
module blrc_back
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   item_valid,
    input  blrc_pkg::item_t        item,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata,
    output logic [1:0]             m_axis_tuser
);

    localparam int DW = blrc_pkg::DATA_W;
    localparam int OW = blrc_pkg::OPND_W;
    localparam int PW = blrc_pkg::PROD_W;
    localparam int SW = blrc_pkg::SUM_W;

    blrc_pkg::back_state_t     state_reg;
    blrc_pkg::back_state_t     state_next;
    blrc_pkg::mode_t           mode_reg;
    blrc_pkg::cmd_t            cmd_reg;
    logic signed [DW-1:0]      gain_tilt_reg;
    logic signed [DW-1:0]      gain_tilt_rate_reg;
    logic signed [DW-1:0]      gain_speed_error_reg;
    logic signed [DW-1:0]      gain_integral_reg;
    logic signed [DW-1:0]      gain_turn_reg;
    logic signed [DW-1:0]      held_tilt_reg;
    logic signed [DW-1:0]      held_tilt_rate_reg;
    logic signed [DW-1:0]      held_speed_a_reg;
    logic signed [DW-1:0]      held_speed_b_reg;
    logic signed [DW-1:0]      integral_reg;
    logic signed [OW-1:0]      err_reg;
    logic signed [OW-1:0]      diff_reg;
    logic [2:0]                step_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [SW-1:0]      acc_reg;
    logic signed [SW-1:0]      turn_reg;
    logic                      out_valid_reg;
    blrc_pkg::cmd_t            out_cmd_reg;
    logic signed [DW-1:0]      out_a_reg;
    logic signed [DW-1:0]      out_b_reg;

    logic                      load_out;
    logic signed [DW-1:0]      mul_a;
    logic signed [OW-1:0]      mul_b;
    logic signed [PW-1:0]      prod_next;
    logic signed [SW-1:0]      term_wide;
    logic signed [OW:0]        half_sum;
    logic signed [OW:0]        neg_half;
    logic signed [SW-1:0]      integ_sum;
    logic signed [SW-1:0]      sum_plus;
    logic signed [SW-1:0]      sum_minus;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blrc_pkg::ST_IDLE:
            begin
                if (item_valid && item.op == blrc_pkg::OP_TICK)
                    state_next = (mode_reg == blrc_pkg::MODE_RUNNING) ?
                                 blrc_pkg::ST_PREP : blrc_pkg::ST_OUT;
            end
            blrc_pkg::ST_PREP:  state_next = blrc_pkg::ST_INTEG;
            blrc_pkg::ST_INTEG: state_next = blrc_pkg::ST_MUL;
            blrc_pkg::ST_MUL:
            begin
                if (step_reg == blrc_pkg::TERM_DRAIN)
                    state_next = blrc_pkg::ST_OUT;
            end
            blrc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = blrc_pkg::ST_IDLE;
            end
            default: state_next = blrc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            blrc_pkg::ST_IDLE: pop      = item_valid;
            blrc_pkg::ST_OUT:  load_out = !out_valid_reg || m_axis_tready;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= blrc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Pick one gain and one operand per multiply step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            blrc_pkg::TERM_TILT:
            begin
                mul_a = gain_tilt_reg;
                mul_b = OW'(held_tilt_reg);
            end
            blrc_pkg::TERM_TILT_RATE:
            begin
                mul_a = gain_tilt_rate_reg;
                mul_b = OW'(held_tilt_rate_reg);
            end
            blrc_pkg::TERM_SPEED_ERROR:
            begin
                mul_a = gain_speed_error_reg;
                mul_b = err_reg;
            end
            blrc_pkg::TERM_INTEGRAL:
            begin
                mul_a = gain_integral_reg;
                mul_b = OW'(integral_reg);
            end
            blrc_pkg::TERM_TURN:
            begin
                mul_a = gain_turn_reg;
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign term_wide = SW'(prod_reg);

    // Mean wheel speed floored, then negated: the linear speed error
    assign half_sum  = (OW'(held_speed_a_reg) + OW'(held_speed_b_reg)) >>> 1;
    assign neg_half  = -half_sum;
    assign integ_sum = SW'(integral_reg) + SW'(err_reg);
    assign sum_plus  = acc_reg + turn_reg;
    assign sum_minus = acc_reg - turn_reg;

    // Configuration, mode, held measurements and arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_tilt_reg        <= blrc_pkg::GAIN_TILT_RESET;
            gain_tilt_rate_reg   <= blrc_pkg::GAIN_TILT_RATE_RESET;
            gain_speed_error_reg <= blrc_pkg::GAIN_SPEED_ERROR_RESET;
            gain_integral_reg    <= blrc_pkg::GAIN_INTEGRAL_RESET;
            gain_turn_reg        <= blrc_pkg::GAIN_TURN_RESET;
            mode_reg             <= blrc_pkg::MODE_NOT_READY;
            held_tilt_reg        <= '0;
            held_tilt_rate_reg   <= '0;
            held_speed_a_reg     <= '0;
            held_speed_b_reg     <= '0;
            integral_reg         <= '0;
            cmd_reg              <= blrc_pkg::CMD_NOP;
            step_reg             <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (blrc_pkg::reg_idx_t'(cfg_index))
                    blrc_pkg::REG_GAIN_TILT:        gain_tilt_reg        <= cfg_data;
                    blrc_pkg::REG_GAIN_TILT_RATE:   gain_tilt_rate_reg   <= cfg_data;
                    blrc_pkg::REG_GAIN_SPEED_ERROR: gain_speed_error_reg <= cfg_data;
                    blrc_pkg::REG_GAIN_INTEGRAL:    gain_integral_reg    <= cfg_data;
                    blrc_pkg::REG_GAIN_TURN:        gain_turn_reg        <= cfg_data;
                    default: ;
                endcase
            end

            // Apply a popped item
            if (pop)
            begin
                unique case (item.op)
                    blrc_pkg::OP_SET_READY:     mode_reg <= blrc_pkg::MODE_READY;
                    blrc_pkg::OP_SET_NOT_READY: mode_reg <= blrc_pkg::MODE_NOT_READY;
                    blrc_pkg::OP_RUN:
                    begin
                        mode_reg           <= blrc_pkg::MODE_RUNNING;
                        held_tilt_reg      <= item.tilt;
                        held_tilt_rate_reg <= item.tilt_rate;
                        held_speed_a_reg   <= item.speed_a;
                        held_speed_b_reg   <= item.speed_b;
                    end
                    blrc_pkg::OP_TICK:
                    begin
                        unique case (mode_reg)
                            blrc_pkg::MODE_READY:   cmd_reg <= blrc_pkg::CMD_START;
                            blrc_pkg::MODE_RUNNING: cmd_reg <= blrc_pkg::CMD_SET_SPEEDS;
                            default:                cmd_reg <= blrc_pkg::CMD_NOP;
                        endcase
                    end
                    default: ;
                endcase
            end

            // Advance the integral with saturation
            if (state_reg == blrc_pkg::ST_INTEG)
                integral_reg <= blrc_pkg::sat32(integ_sum);

            // Step counter of the multiply sequence
            if (state_reg == blrc_pkg::ST_MUL)
                step_reg <= step_reg + 3'd1;
            else
                step_reg <= '0;
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (pop && item.op == blrc_pkg::OP_TICK)
        begin
            acc_reg  <= '0;
            turn_reg <= '0;
        end
        if (state_reg == blrc_pkg::ST_PREP)
        begin
            err_reg  <= OW'(neg_half);
            diff_reg <= OW'(held_speed_b_reg) - OW'(held_speed_a_reg);
        end
        if (state_reg == blrc_pkg::ST_MUL)
        begin
            prod_reg <= prod_next;
            // Fold in the product of the previous step, floored
            if (step_reg == blrc_pkg::TERM_DRAIN)
                turn_reg <= term_wide >>> (FRAC_BITS + 1);
            else if (step_reg != blrc_pkg::TERM_TILT)
                acc_reg <= acc_reg + (term_wide >>> FRAC_BITS);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_cmd_reg <= cmd_reg;
            out_a_reg   <= blrc_pkg::sat32(sum_plus);
            out_b_reg   <= blrc_pkg::sat32(sum_minus);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_cmd_reg;
    assign m_axis_tdata  = {out_b_reg, out_a_reg};

endmodule

// ----- bench/blrc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the balancing robot controller: tracks gain writes, predicts
// each tick's command beat, and compares the output stream. Depends on blrc_pkg.
module blrc_checker
    import blrc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    // status_code[7:0], tilt[39:8], tilt_rate[71:40],
    // wheel_speed_a[103:72], wheel_speed_b[135:104]
    input  logic [135:0]  s_axis_tdata,
    // kind[0]
    input  logic          s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // setpoint_a[31:0], setpoint_b[63:32]
    input  logic [63:0]   m_axis_tdata,
    // command[1:0]
    input  logic [1:0]    m_axis_tuser,
    output int            fail_count,
    output int            outstanding,
    output int            commands_checked,
    output int            drive_commands
);

    localparam int REPORT_MAX = 10;

    typedef struct {
        cmd_t               command;
        logic signed [31:0] sp_a;
        logic signed [31:0] sp_b;
    } wheel_cmd_t;

    // Gains as last written
    logic signed [31:0] k_tilt;
    logic signed [31:0] k_tilt_rate;
    logic signed [31:0] k_speed;
    logic signed [31:0] k_integral;
    logic signed [31:0] k_turn;

    // Controller state mirror
    mode_t              mode;
    logic signed [31:0] speed_integral;
    logic signed [31:0] held_tilt;
    logic signed [31:0] held_tilt_rate;
    logic signed [31:0] held_a;
    logic signed [31:0] held_b;

    wheel_cmd_t         pending_cmds[$];
    wheel_cmd_t         want;
    logic [7:0]         status;
    cmd_t               got_cmd;
    logic signed [31:0] got_a;
    logic signed [31:0] got_b;
    int                 reported;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (x < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // Advance the speed integral and form the command a tick produces now
    function automatic wheel_cmd_t tick_command();
        wheel_cmd_t r;
        longint     sa;
        longint     sb;
        longint     err;
        longint     u;
        longint     turn;
        r.command = CMD_NOP;
        r.sp_a    = '0;
        r.sp_b    = '0;
        case (mode)
            MODE_READY:
                r.command = CMD_START;
            MODE_RUNNING:
            begin
                sa  = held_a;
                sb  = held_b;
                err = -((sa + sb) >>> 1);
                speed_integral = clamp32(longint'(speed_integral) + err);
                u = ((longint'(k_tilt) * held_tilt) >>> FRAC_BITS)
                  + ((longint'(k_tilt_rate) * held_tilt_rate) >>> FRAC_BITS)
                  + ((longint'(k_speed) * err) >>> FRAC_BITS)
                  + ((longint'(k_integral) * speed_integral) >>> FRAC_BITS);
                turn = (longint'(k_turn) * (sb - sa)) >>> (FRAC_BITS + 1);
                r.command = CMD_SET_SPEEDS;
                r.sp_a    = clamp32(u + turn);
                r.sp_b    = clamp32(u - turn);
            end
            default:
                r.command = CMD_NOP;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_tilt           = GAIN_TILT_RESET;
            k_tilt_rate      = GAIN_TILT_RATE_RESET;
            k_speed          = GAIN_SPEED_ERROR_RESET;
            k_integral       = GAIN_INTEGRAL_RESET;
            k_turn           = GAIN_TURN_RESET;
            mode             = MODE_NOT_READY;
            speed_integral   = '0;
            held_tilt        = '0;
            held_tilt_rate   = '0;
            held_a           = '0;
            held_b           = '0;
            pending_cmds.delete();
            outstanding      = 0;
            fail_count       = 0;
            commands_checked = 0;
            drive_commands   = 0;
            reported         = 0;
        end
        else
        begin
            // Track gain writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_TILT:        k_tilt      = cfg_data;
                    REG_GAIN_TILT_RATE:   k_tilt_rate = cfg_data;
                    REG_GAIN_SPEED_ERROR: k_speed     = cfg_data;
                    REG_GAIN_INTEGRAL:    k_integral  = cfg_data;
                    REG_GAIN_TURN:        k_turn      = cfg_data;
                    default: ;
                endcase
            end

            // Compare a result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_cmd = cmd_t'(m_axis_tuser);
                got_a   = m_axis_tdata[31:0];
                got_b   = m_axis_tdata[63:32];
                commands_checked++;
                if (pending_cmds.size() == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_MAX)
                        $display("%0t: unexpected command beat cmd %0d a %0d b %0d",
                                 $realtime, got_cmd, got_a, got_b);
                    reported++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (want.command == CMD_SET_SPEEDS)
                        drive_commands++;
                    if (got_cmd !== want.command || got_a !== want.sp_a
                        || got_b !== want.sp_b)
                    begin
                        fail_count++;
                        if (reported < REPORT_MAX)
                            $display("%0t: mismatch: want cmd %0d a %0d b %0d",
                                     $realtime, want.command, want.sp_a, want.sp_b,
                                     ", got cmd %0d a %0d b %0d",
                                     got_cmd, got_a, got_b);
                        reported++;
                    end
                end
            end

            // Update the mirror on each accepted input beat
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_TICK)
                    pending_cmds.push_back(tick_command());
                else
                begin
                    status = s_axis_tdata[7:0];
                    if (status == STATUS_READY)
                        mode = MODE_READY;
                    else if (status == STATUS_NOT_READY)
                        mode = MODE_NOT_READY;
                    else if (status == STATUS_RUNNING)
                    begin
                        mode           = MODE_RUNNING;
                        held_tilt      = s_axis_tdata[39:8];
                        held_tilt_rate = s_axis_tdata[71:40];
                        held_a         = s_axis_tdata[103:72];
                        held_b         = s_axis_tdata[135:104];
                    end
                end
            end

            outstanding = pending_cmds.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the balancing robot controller: clock, reset, gain writes,
// status/tick stimulus and the verdict. Depends on blrc_pkg and blrc_checker.
module tb;
    import blrc_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int DRAIN       = 40;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 180;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [7:0]  STATUS_ALL_ONES = {STATUS_W{1'b1}};

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata;
    logic          s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [63:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    int            fail_count;
    int            outstanding;
    int            commands_checked;
    int            drive_commands;

    logic          calm;
    int            beats_sent;
    int            ticks_sent;
    int            gain_settings;
    logic [31:0]   gain_set [5];

    balancing_robot_lqr_controller #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    blrc_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .commands_checked (commands_checked),
        .drive_commands   (drive_commands)
    );

    always #10 clk = ~clk;

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Measurements: mostly near-balance values, some full range, some corners
    function automatic logic [31:0] pick_measure();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3:       return '1;
            default: return 32'd1;
        endcase
    endfunction

    // Result side: random stalls, released during calm stretches
    initial
    begin
        int hold;
        int r;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    m_axis_tready <= 1'b1;
                else
                begin
                    hold = (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Present one input beat and hold it until accepted
    task automatic send_beat(input logic kind, input logic [7:0] code,
                             input logic [31:0] tilt, input logic [31:0] rate,
                             input logic [31:0] wa, input logic [31:0] wb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {wb, wa, rate, tilt, code};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        beats_sent++;
        if (kind == KIND_TICK)
            ticks_sent++;
    endtask

    task automatic tick();
        send_beat(KIND_TICK, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic status_beat(input logic [7:0] code, input logic [31:0] tilt,
                               input logic [31:0] rate, input logic [31:0] wa,
                               input logic [31:0] wb);
        send_beat(KIND_PACKET, code, tilt, rate, wa, wb);
    endtask

    // Wait until every command is back and the back end has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Write all five gains, sometimes followed by a write to an unused index
    task automatic load_gains();
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= 3'(i);
            cfg_data  <= gain_set[i];
            cfg_we    <= 1'b1;
            @(negedge clk);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_index <= 3'($urandom_range(int'(REG_GAIN_TURN) + 1, (1 << IDX_W) - 1));
            cfg_data  <= $urandom;
            cfg_we    <= 1'b1;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        gain_settings++;
    endtask

    task automatic pick_gains(input int phase);
        for (int i = 0; i < 5; i++)
        begin
            case (phase)
                1: gain_set[i] = $urandom;
                2: gain_set[i] = S32_MAX;
                3: gain_set[i] = S32_MIN;
                4:
                    case ($urandom_range(0, 2))
                        0:       gain_set[i] = '0;
                        1:       gain_set[i] = S32_MAX;
                        default: gain_set[i] = S32_MIN;
                    endcase
                5: gain_set[i] = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
                default: ;
            endcase
        end
        // Restore the power-on gains in the last phase
        if (phase == 6)
        begin
            gain_set[REG_GAIN_TILT]        = GAIN_TILT_RESET;
            gain_set[REG_GAIN_TILT_RATE]   = GAIN_TILT_RATE_RESET;
            gain_set[REG_GAIN_SPEED_ERROR] = GAIN_SPEED_ERROR_RESET;
            gain_set[REG_GAIN_INTEGRAL]    = GAIN_INTEGRAL_RESET;
            gain_set[REG_GAIN_TURN]        = GAIN_TURN_RESET;
        end
    endtask

    // One random item; running packets and ticks dominate
    task automatic random_item(output logic counted);
        int r;
        logic [7:0] code;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 40)
            tick();
        else
        begin
            if (r < 75)
                code = STATUS_RUNNING;
            else if (r < 83)
                code = STATUS_READY;
            else if (r < 90)
                code = STATUS_NOT_READY;
            else
            begin
                code = 8'($urandom_range(int'(STATUS_RUNNING) + 1, (1 << STATUS_W) - 1));
                counted = 1'b0;
            end
            status_beat(code, pick_measure(), pick_measure(), pick_measure(), pick_measure());
        end
    endtask

    initial
    begin
        logic counted;
        int   done;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PACKET;
        calm          = 1'b0;
        beats_sent    = 0;
        ticks_sent    = 0;
        gain_settings = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: mode transitions, ignored codes, measurement corners
        tick();
        status_beat(STATUS_NOT_READY, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
        tick();
        status_beat(STATUS_READY, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        tick();
        status_beat(STATUS_ALL_ONES, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        tick();
        status_beat(STATUS_RUNNING, '0, '0, '0, '0);
        tick();
        status_beat(STATUS_RUNNING, S32_MAX, S32_MIN, S32_MAX, S32_MAX);
        tick();
        tick();
        status_beat(STATUS_RUNNING, S32_MIN, S32_MAX, S32_MIN, S32_MIN);
        tick();
        tick();
        tick();
        status_beat(STATUS_RUNNING, 32'h0000_8000, '1, S32_MAX, S32_MIN);
        tick();
        status_beat(STATUS_READY, '0, '0, '0, '0);
        tick();
        status_beat(8'(int'(STATUS_RUNNING) + 1), '1, '1, '1, '1);
        tick();
        status_beat(STATUS_RUNNING, 32'h0000_1000, 32'hFFFF_E000, 32'h0002_0000, 32'h0001_8000);
        status_beat(STATUS_ALL_ONES, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        tick();
        status_beat(STATUS_NOT_READY, '0, '0, '0, '0);
        tick();

        // Random phases, each under its own gain setting
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                pick_gains(p);
                load_gains();
            end
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                if (done % 50 == 0)
                    calm = ($urandom_range(0, 4) == 0);
                random_item(counted);
                if (counted)
                    done++;
            end
        end

        calm = 1'b0;
        settle();
        $display("Sent %0d input beats (%0d ticks) under %0d gain settings;",
                 beats_sent, ticks_sent, gain_settings);
        $display("checked %0d command beats, %0d of them with wheel setpoints.",
                 commands_checked, drive_commands);
        if (outstanding != 0)
            $display("%0d expected command beats never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/blrc_pkg.sv
hw/rtl/blrc_queue.sv
hw/rtl/blrc_front.sv
hw/rtl/blrc_back.sv
hw/rtl/balancing_robot_lqr_controller.sv
bench/blrc_checker.sv
bench/tb.sv
